// File: rtl/core/dajcm_pkg.sv
// Shared types and constants for the dual-arm jog command mapper.
// No dependencies; imported by every module under rtl/core.
package dajcm_pkg;

   // command codes on the result channel
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEADBAND       = 2'd0;
   localparam logic [1:0] CSR_MAX_VELOCITY   = 2'd1;
   localparam logic [1:0] CSR_ANALOG_SCALING = 2'd2;

   localparam logic [14:0] DEADBAND_RST     = 15'd3277;
   localparam logic [14:0] MAX_VELOCITY_RST = 15'd7680;
   localparam logic [14:0] VEL_CAP          = 15'd25600;

   // result slots of one tick, in emission order; slot bit 0 is the arm
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_RST_L   = 0;
   localparam int SLOT_RST_R   = 1;
   localparam int SLOT_MSTOP_L = 2;
   localparam int SLOT_MSTOP_R = 3;
   localparam int SLOT_START_L = 4;
   localparam int SLOT_START_R = 5;
   localparam int SLOT_ESTOP_L = 6;
   localparam int SLOT_ESTOP_R = 7;

   // slot index bits [2:1] name the kind of command
   localparam logic [1:0] KIND_RESET = 2'd0;
   localparam logic [1:0] KIND_MSTOP = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_ESTOP = 2'd3;

   typedef struct packed {
      logic               joy_present;
      logic               layout_ok;
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic signed [15:0] stick_z;
      logic [7:0]         buttons;
   } req_type;

   typedef struct packed {
      logic [1:0]  command;
      logic        arm;
      logic [2:0]  jog_axis;
      logic        jog_direction;
      logic [14:0] jog_velocity;
      logic        last;
   } rsp_type;

   // one classified tick, handed from the front to the back
   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic [2:0]           axis;
      logic                 ldir;
      logic                 rdir;
      logic [15:0]          mag;
      logic                 scale;
   } plan_type;

endpackage

// File: rtl/core/dajcm_front.sv
// Front end: takes joystick ticks, tracks button edges, arm mode and jog state,
// and turns each tick into a plan of up to six commands. Uses dajcm_pkg.
module dajcm_front
   import dajcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic [14:0] deadband,
   input  logic        analog_scaling,
   output logic        q_push,
   output plan_type    q_data,
   input  logic        q_ready
);

   typedef enum logic [1:0] {
      MODE_BOTH  = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_RIGHT = 2'd2
   } arm_mode_type;

   logic         reset_button_was_ff, reset_button_was_in;
   logic         mode_button_was_ff, mode_button_was_in;
   arm_mode_type arm_mode_ff, arm_mode_in;
   logic         was_jogging_ff, was_jogging_in;

   logic        accept;
   logic        rst_btn, mode_btn, rst_edge, mode_edge;
   logic [15:0] mag_x, mag_y, mag_z;
   logic        hit_x, hit_y, hit_z;
   logic        jog, was_jog_eff, sel_left, sel_right;
   plan_type    plan;

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      logic [15:0] u;
      begin
         u = v;
         mag16 = u[15] ? (~u + 16'd1) : u;
      end
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = q_ready;

   assign rst_btn   = req_data.buttons[3];
   assign mode_btn  = req_data.buttons[1];
   assign rst_edge  = rst_btn && !reset_button_was_ff;
   assign mode_edge = mode_btn && !mode_button_was_ff;

   assign mag_x = mag16(req_data.stick_x);
   assign mag_y = mag16(req_data.stick_y);
   assign mag_z = mag16(req_data.stick_z);
   assign hit_x = mag_x > {1'b0, deadband};
   assign hit_y = mag_y > {1'b0, deadband};
   assign hit_z = mag_z > {1'b0, deadband};

   always_comb begin
      unique case (arm_mode_ff)
         MODE_BOTH:  arm_mode_in = mode_edge ? MODE_LEFT : arm_mode_ff;
         MODE_LEFT:  arm_mode_in = mode_edge ? MODE_RIGHT : arm_mode_ff;
         MODE_RIGHT: arm_mode_in = mode_edge ? MODE_BOTH : arm_mode_ff;
         default:    arm_mode_in = mode_edge ? MODE_BOTH : arm_mode_ff;
      endcase
      if (!req_data.layout_ok) begin
         arm_mode_in = arm_mode_ff;
      end
   end

   // start jogs go to the arms of the mode after this tick's mode step
   assign sel_left    = (arm_mode_in == MODE_BOTH) || (arm_mode_in == MODE_LEFT);
   assign sel_right   = (arm_mode_in == MODE_BOTH) || (arm_mode_in == MODE_RIGHT);
   assign was_jog_eff = was_jogging_ff && !mode_edge;

   always_comb begin
      plan       = '0;
      jog        = 1'b1;
      plan.axis  = 3'd0;
      plan.ldir  = 1'b0;
      plan.rdir  = 1'b0;
      plan.mag   = 16'd0;
      plan.scale = 1'b0;
      if (hit_x) begin
         plan.axis  = 3'd1;
         plan.ldir  = !req_data.stick_x[15];
         plan.rdir  = req_data.stick_x[15];
         plan.mag   = mag_x;
         plan.scale = analog_scaling;
      end else if (hit_y) begin
         plan.axis  = 3'd2;
         plan.ldir  = !req_data.stick_y[15];
         plan.rdir  = req_data.stick_y[15];
         plan.mag   = mag_y;
         plan.scale = analog_scaling;
      end else if (hit_z) begin
         plan.axis  = 3'd3;
         plan.ldir  = !req_data.stick_z[15];
         plan.rdir  = req_data.stick_z[15];
         plan.mag   = mag_z;
         plan.scale = analog_scaling;
      end else if (req_data.buttons[5]) begin
         plan.axis = 3'd4;
         plan.ldir = 1'b1;
      end else if (req_data.buttons[7]) begin
         plan.axis = 3'd4;
         plan.rdir = 1'b1;
      end else if (req_data.buttons[4]) begin
         plan.axis = 3'd5;
         plan.ldir = 1'b1;
      end else if (req_data.buttons[6]) begin
         plan.axis = 3'd5;
         plan.rdir = 1'b1;
      end else if (req_data.buttons[2]) begin
         plan.axis = 3'd6;
         plan.ldir = 1'b1;
         plan.rdir = 1'b1;
      end else if (req_data.buttons[0]) begin
         plan.axis = 3'd6;
      end else begin
         jog = 1'b0;
      end

      if (req_data.layout_ok) begin
         plan.slots[SLOT_RST_L]   = rst_edge;
         plan.slots[SLOT_RST_R]   = rst_edge;
         plan.slots[SLOT_MSTOP_L] = mode_edge;
         plan.slots[SLOT_MSTOP_R] = mode_edge;
         plan.slots[SLOT_START_L] = jog && sel_left;
         plan.slots[SLOT_START_R] = jog && sel_right;
         plan.slots[SLOT_ESTOP_L] = !jog && was_jog_eff;
         plan.slots[SLOT_ESTOP_R] = !jog && was_jog_eff;
      end else begin
         plan.slots[SLOT_ESTOP_L] = was_jogging_ff;
         plan.slots[SLOT_ESTOP_R] = was_jogging_ff;
      end
   end

   always_comb begin
      reset_button_was_in = reset_button_was_ff;
      mode_button_was_in  = mode_button_was_ff;
      was_jogging_in      = was_jogging_ff;
      if (accept && req_data.joy_present) begin
         if (req_data.layout_ok) begin
            reset_button_was_in = rst_btn;
            mode_button_was_in  = mode_btn;
            was_jogging_in      = jog;
         end else begin
            was_jogging_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_button_was_ff <= 1'b0;
         mode_button_was_ff  <= 1'b0;
         arm_mode_ff         <= MODE_BOTH;
         was_jogging_ff      <= 1'b0;
      end else begin
         reset_button_was_ff <= reset_button_was_in;
         mode_button_was_ff  <= mode_button_was_in;
         was_jogging_ff      <= was_jogging_in;
         if (accept && req_data.joy_present) begin
            arm_mode_ff <= arm_mode_in;
         end
      end
   end

   // ticks that cause no command never enter the queue
   assign q_push = accept && req_data.joy_present && (plan.slots != '0);
   assign q_data = plan;

   a_mode_reachable: assert property (@(posedge clock) disable iff (reset)
      (arm_mode_ff == MODE_BOTH) || (arm_mode_ff == MODE_LEFT) || (arm_mode_ff == MODE_RIGHT))
      else $error("arm mode left its three-way cycle");

   a_mode_step_stops: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.joy_present && req_data.layout_ok && mode_edge)
      |=> !was_jogging_ff || $past(jog))
      else $error("jog flag survived a mode change without a new jog");

   a_layout_bad_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.joy_present && !req_data.layout_ok) |=> !was_jogging_ff)
      else $error("unusable snapshot left the jog flag set");

endmodule

// File: rtl/core/dajcm_queue.sv
// Short plan queue between front and back so each side stalls on its own.
// Uses dajcm_pkg for the plan type.
module dajcm_queue
   import dajcm_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  plan_type push_data,
   output logic     in_ready,
   input  logic     pop,
   output logic     out_valid,
   output plan_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   plan_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;
   assign out_data  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> in_ready)
      else $error("plan pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> out_valid)
      else $error("plan popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

// File: rtl/core/dajcm_back.sv
// Back end: walks the slot mask of each plan and emits one command per cycle
// into a free result register; one multiplier scales velocity. Uses dajcm_pkg.
module dajcm_back
   import dajcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  plan_type    q_data,
   output logic        q_pop,
   input  logic [14:0] max_velocity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   plan_type             work_ff, work_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 out_free, emit, load;
   logic [NUM_SLOTS-1:0] low_bit, slots_after;
   logic [2:0]           idx;
   logic [14:0]          vmax;
   logic [30:0]          prod;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (work_ff.slots != '0) && out_free;
   assign low_bit  = work_ff.slots & (~work_ff.slots + 1'b1);

   always_comb begin
      idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (work_ff.slots[i]) begin
            idx = 3'(i);
         end
      end
   end

   assign slots_after = emit ? (work_ff.slots & ~low_bit) : work_ff.slots;
   assign load        = (slots_after == '0) && q_valid;
   assign q_pop       = load;

   always_comb begin
      work_in = work_ff;
      work_in.slots = slots_after;
      if (load) begin
         work_in = q_data;
      end
   end

   assign vmax = (max_velocity > VEL_CAP) ? VEL_CAP : max_velocity;
   assign prod = 31'(work_ff.mag) * 31'(vmax);

   always_comb begin
      rsp_in               = '0;
      rsp_in.arm           = idx[0];
      rsp_in.last          = (work_ff.slots & ~low_bit) == '0;
      unique case (idx[2:1])
         KIND_RESET: rsp_in.command = CMD_RESET;
         KIND_MSTOP: rsp_in.command = CMD_STOP;
         KIND_ESTOP: rsp_in.command = CMD_STOP;
         KIND_START: begin
            rsp_in.command       = CMD_START;
            rsp_in.jog_axis      = work_ff.axis;
            rsp_in.jog_direction = idx[0] ? work_ff.rdir : work_ff.ldir;
            rsp_in.jog_velocity  = work_ff.scale ? prod[29:15] : vmax;
         end
         default: rsp_in.command = CMD_STOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff <= work_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_start_has_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.command == CMD_START) |-> rsp_ff.jog_axis != 3'd0)
      else $error("start jog without an axis");

   a_velocity_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.jog_velocity <= VEL_CAP)
      else $error("jog velocity above cap");

   a_load_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (work_ff.slots == '0) || (emit && $onehot(work_ff.slots)))
      else $error("new plan loaded over unfinished commands");

endmodule

// File: rtl/core/dual_arm_jog_command_mapper_core.sv
// An accepted tick passes through the plan queue and the back end's work register
// into the result register; further commands of the tick follow one per cycle while
// the result register is free. Throughput: a tick of n commands holds the back end
// for all n of them (up to six); the front takes one tick per cycle while the
// plan queue has room. Ticks that cause no command never enter the queue.
// Reset (synchronous, active high) restores register defaults and clears control state.
module dual_arm_jog_command_mapper_core
   import dajcm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [14:0] csr_wdata
);

   logic [14:0] deadband_ff;
   logic [14:0] max_velocity_ff;
   logic        analog_scaling_ff;

   logic        push, push_ready, pop, q_valid;
   plan_type    push_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff       <= DEADBAND_RST;
         max_velocity_ff   <= MAX_VELOCITY_RST;
         analog_scaling_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEADBAND:       deadband_ff       <= csr_wdata;
            CSR_MAX_VELOCITY:   max_velocity_ff   <= csr_wdata;
            CSR_ANALOG_SCALING: analog_scaling_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   dajcm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .deadband       (deadband_ff),
      .analog_scaling (analog_scaling_ff),
      .q_push         (push),
      .q_data         (push_data),
      .q_ready        (push_ready)
   );

   dajcm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (push_ready),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   dajcm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (pop),
      .max_velocity (max_velocity_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// File: verif/tb_dual_arm_jog_command_mapper_core.sv
// Testbench for dual_arm_jog_command_mapper_core: directed and random joystick ticks,
// checked against an in-bench command predictor. Depends on dajcm_pkg and the core RTL.
module tb_dual_arm_jog_command_mapper_core;
   import dajcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // button bits
   localparam int BTN_RZ_NEG    = 0;
   localparam int BTN_MODE      = 1;
   localparam int BTN_RZ_POS    = 2;
   localparam int BTN_ERR_RESET = 3;
   localparam int BTN_RY_POS    = 4;
   localparam int BTN_RX_POS    = 5;
   localparam int BTN_RY_NEG    = 6;
   localparam int BTN_RX_NEG    = 7;

   // cartesian jog axes
   localparam logic [2:0] AXIS_NONE = 3'd0;
   localparam logic [2:0] AXIS_X    = 3'd1;
   localparam logic [2:0] AXIS_Y    = 3'd2;
   localparam logic [2:0] AXIS_Z    = 3'd3;
   localparam logic [2:0] AXIS_RX   = 3'd4;
   localparam logic [2:0] AXIS_RY   = 3'd5;
   localparam logic [2:0] AXIS_RZ   = 3'd6;

   localparam logic ARM_LEFT  = 1'b0;
   localparam logic ARM_RIGHT = 1'b1;

   typedef enum logic [1:0] {
      MODE_BOTH       = 2'd0,
      MODE_LEFT_ONLY  = 2'd1,
      MODE_RIGHT_ONLY = 2'd2
   } arm_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_DEADBAND;
   logic [14:0] csr_wdata = '0;

   dual_arm_jog_command_mapper_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the block state and registers
   logic [14:0]  cfg_deadband = DEADBAND_RST;
   logic [14:0]  cfg_max_velocity = MAX_VELOCITY_RST;
   logic         cfg_scaling = 1'b0;
   logic         reset_btn_was = 1'b0;
   logic         mode_btn_was = 1'b0;
   arm_mode_type arm_mode = MODE_BOTH;
   logic         was_jogging = 1'b0;

   rsp_type tick_cmds[$];
   rsp_type pending_cmds[$];
   req_type outgoing[$];

   int error_count = 0;
   int ticks_queued = 0;
   int ticks_accepted = 0;
   int ignored_ticks = 0;
   int cmds_checked = 0;
   int input_stall_cycles = 0;
   int settings_used = 1;
   bit idle_gaps = 1'b1;
   bit tick_busy = 1'b0;
   int send_gap = 0;
   int hold_len = 0;
   int hold_seq = 0;

   function automatic logic [14:0] capped_velocity();
      return (cfg_max_velocity > VEL_CAP) ? VEL_CAP : cfg_max_velocity;
   endfunction

   function automatic void add_cmd(logic [1:0] cmd, logic arm, logic [2:0] axis, logic dir,
                                   logic [14:0] vel);
      rsp_type c;
      c.command = cmd;
      c.arm = arm;
      c.jog_axis = axis;
      c.jog_direction = dir;
      c.jog_velocity = vel;
      c.last = 1'b0;
      tick_cmds.push_back(c);
   endfunction

   function automatic void stop_both();
      add_cmd(CMD_STOP, ARM_LEFT, AXIS_NONE, 1'b0, '0);
      add_cmd(CMD_STOP, ARM_RIGHT, AXIS_NONE, 1'b0, '0);
   endfunction

   function automatic void add_starts(logic [2:0] axis, logic ldir, logic rdir,
                                      logic [14:0] vel);
      if (arm_mode == MODE_BOTH || arm_mode == MODE_LEFT_ONLY)
         add_cmd(CMD_START, ARM_LEFT, axis, ldir, vel);
      if (arm_mode == MODE_BOTH || arm_mode == MODE_RIGHT_ONLY)
         add_cmd(CMD_START, ARM_RIGHT, axis, rdir, vel);
   endfunction

   // a stick jogs only when its magnitude strictly exceeds the deadband
   function automatic bit try_stick(logic signed [15:0] v, logic [2:0] axis);
      logic [15:0] mag;
      logic [31:0] vel;
      mag = v[15] ? 16'(-v) : 16'(v);
      if (mag <= {1'b0, cfg_deadband})
         return 1'b0;
      vel = capped_velocity();
      if (cfg_scaling)
         vel = (32'(mag) * vel) >> 15;
      add_starts(axis, !v[15], v[15], 15'(vel));
      return 1'b1;
   endfunction

   function automatic void predict_tick(req_type t);
      logic    rst_btn;
      logic    mode_btn;
      bit      jogging;
      rsp_type tail;
      if (!t.joy_present) begin
         ignored_ticks++;
         return;
      end
      tick_cmds.delete();
      if (!t.layout_ok) begin
         if (was_jogging)
            stop_both();
         was_jogging = 1'b0;
      end else begin
         rst_btn = t.buttons[BTN_ERR_RESET];
         mode_btn = t.buttons[BTN_MODE];
         if (rst_btn && !reset_btn_was) begin
            add_cmd(CMD_RESET, ARM_LEFT, AXIS_NONE, 1'b0, '0);
            add_cmd(CMD_RESET, ARM_RIGHT, AXIS_NONE, 1'b0, '0);
         end
         reset_btn_was = rst_btn;
         if (mode_btn && !mode_btn_was) begin
            stop_both();
            case (arm_mode)
               MODE_BOTH:      arm_mode = MODE_LEFT_ONLY;
               MODE_LEFT_ONLY: arm_mode = MODE_RIGHT_ONLY;
               default:        arm_mode = MODE_BOTH;
            endcase
            was_jogging = 1'b0;
         end
         mode_btn_was = mode_btn;

         jogging = try_stick(t.stick_x, AXIS_X);
         if (!jogging)
            jogging = try_stick(t.stick_y, AXIS_Y);
         if (!jogging)
            jogging = try_stick(t.stick_z, AXIS_Z);
         if (!jogging) begin
            jogging = 1'b1;
            if (t.buttons[BTN_RX_POS])
               add_starts(AXIS_RX, 1'b1, 1'b0, capped_velocity());
            else if (t.buttons[BTN_RX_NEG])
               add_starts(AXIS_RX, 1'b0, 1'b1, capped_velocity());
            else if (t.buttons[BTN_RY_POS])
               add_starts(AXIS_RY, 1'b1, 1'b0, capped_velocity());
            else if (t.buttons[BTN_RY_NEG])
               add_starts(AXIS_RY, 1'b0, 1'b1, capped_velocity());
            else if (t.buttons[BTN_RZ_POS])
               add_starts(AXIS_RZ, 1'b1, 1'b1, capped_velocity());
            else if (t.buttons[BTN_RZ_NEG])
               add_starts(AXIS_RZ, 1'b0, 1'b0, capped_velocity());
            else
               jogging = 1'b0;
         end
         if (!jogging && was_jogging)
            stop_both();
         was_jogging = jogging;
      end
      if (tick_cmds.size() > 0) begin
         tail = tick_cmds.pop_back();
         tail.last = 1'b1;
         tick_cmds.push_back(tail);
      end
      foreach (tick_cmds[i])
         pending_cmds.push_back(tick_cmds[i]);
   endfunction

   function automatic int pick_gap(int quiet_pct);
      int r;
      if (!idle_gaps)
         return 0;
      r = $urandom_range(99);
      if (r < quiet_pct)
         return 0;
      else if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // input side: one item at a time from the outgoing queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (tick_busy) begin
         // hold valid and payload until accepted
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (outgoing.size() > 0) begin
         req_data <= outgoing.pop_front();
         req_valid <= 1'b1;
         tick_busy = 1'b1;
         send_gap = pick_gap(60);
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid) begin
         if (req_ready) begin
            predict_tick(req_data);
            tick_busy = 1'b0;
            ticks_accepted++;
         end else begin
            input_stall_cycles++;
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      int r;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!idle_gaps) begin
         rsp_ready <= 1'b1;
      end else begin
         r = $urandom_range(99);
         if (r < 70) begin
            rsp_ready <= 1'b1;
         end else if (r < 95) begin
            stall_left = $urandom_range(2);
            rsp_ready <= 1'b0;
         end else begin
            stall_left = $urandom_range(40, 10);
            rsp_ready <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [14:0] exp_v, logic [14:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_c;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected command: command %0d arm %0d", rsp_data.command, rsp_data.arm);
            error_count++;
         end else begin
            exp_c = pending_cmds.pop_front();
            check_field("command", 15'(exp_c.command), 15'(rsp_data.command));
            check_field("arm", 15'(exp_c.arm), 15'(rsp_data.arm));
            check_field("jog_axis", 15'(exp_c.jog_axis), 15'(rsp_data.jog_axis));
            check_field("jog_direction", 15'(exp_c.jog_direction),
                        15'(rsp_data.jog_direction));
            check_field("jog_velocity", exp_c.jog_velocity, rsp_data.jog_velocity);
            check_field("last", 15'(exp_c.last), 15'(rsp_data.last));
            cmds_checked++;
         end
      end
   end

   task automatic send_tick(req_type t);
      int id;
      outgoing.push_back(t);
      ticks_queued++;
      id = ticks_queued;
      wait (ticks_accepted >= id);
   endtask

   function automatic req_type make_tick(logic present, logic layout, logic signed [15:0] x,
                                         logic signed [15:0] y, logic signed [15:0] z,
                                         logic [7:0] buttons);
      req_type t;
      t.joy_present = present;
      t.layout_ok = layout;
      t.stick_x = x;
      t.stick_y = y;
      t.stick_z = z;
      t.buttons = buttons;
      return t;
   endfunction

   // ends at a falling edge with no command outstanding and the block settled
   task automatic wait_idle();
      wait (ticks_accepted == ticks_queued);
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(logic [14:0] deadband, logic [14:0] max_vel, logic scaling);
      csr_we <= 1'b1;
      csr_addr <= CSR_DEADBAND;
      csr_wdata <= deadband;
      @(negedge clock);
      csr_addr <= CSR_MAX_VELOCITY;
      csr_wdata <= max_vel;
      @(negedge clock);
      csr_addr <= CSR_ANALOG_SCALING;
      csr_wdata <= {14'd0, scaling};
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_deadband = deadband;
      cfg_max_velocity = max_vel;
      cfg_scaling = scaling;
      settings_used++;
   endtask

   task automatic test_directed();
      send_tick(make_tick(1'b0, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 8'hFF));  // ignored tick
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h08));      // error reset
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h08));      // held, no edge
      send_tick(make_tick(1'b1, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, -16'sd32768, 16'sd0, 16'sd0, 8'h00));
      // equal to the deadband does not jog, one past it does
      send_tick(make_tick(1'b1, 1'b1, 16'sd3277, -16'sd3278, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, -16'sd3277, 16'sd0, 16'sd20000, 8'hFF));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h20));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'hC0));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h50));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h40));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h05));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h01));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h00));      // jog ends
      send_tick(make_tick(1'b1, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b0, 16'sd32767, 16'sd0, 16'sd0, 8'hFF));  // bad layout
      send_tick(make_tick(1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 8'h00));
      // mode steps with a stick held: left only, right only, then back to both
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd30000, 16'sd0, 8'h02));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd30000, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, -16'sd30000, 8'h02));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 8'h0A));  // six commands
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h00));
      wait_idle();
   endtask

   task automatic test_register_extremes();
      // zero deadband, velocity above the cap, scaled by stick magnitude
      write_config(15'd0, 15'd32767, 1'b1);
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd1, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, -16'sd32768, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, -16'sd1, 16'sd0, 8'h80));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h10));
      wait_idle();
      write_config(15'd32767, 15'd0, 1'b1);
      send_tick(make_tick(1'b1, 1'b1, 16'sd32767, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, -16'sd32768, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h04));
      wait_idle();
      write_config(15'd12000, VEL_CAP, 1'b0);
      send_tick(make_tick(1'b1, 1'b1, -16'sd12001, 16'sd0, 16'sd0, 8'h00));
      send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h00));
      wait_idle();
   endtask

   function automatic logic signed [15:0] rand_axis();
      int r;
      int m;
      r = $urandom_range(99);
      if (r < 55) begin
         m = $urandom_range(cfg_deadband);
         return $urandom_range(1) ? 16'(-m) : 16'(m);
      end else if (r < 63) begin
         return 16'sd0;
      end else if (r < 88) begin
         return 16'($urandom);
      end
      case ($urandom_range(5))
         0:       return 16'sd32767;
         1:       return -16'sd32768;
         2:       return 16'(cfg_deadband);
         3:       return 16'(-int'(cfg_deadband));
         4:       return 16'(int'(cfg_deadband) + 1);
         default: return 16'(-int'(cfg_deadband) - 1);
      endcase
   endfunction

   function automatic req_type rand_tick(logic [7:0] prev_buttons);
      req_type t;
      int      r;
      t.joy_present = ($urandom_range(19) != 0);
      t.layout_ok = ($urandom_range(11) != 0);
      t.stick_x = rand_axis();
      t.stick_y = rand_axis();
      t.stick_z = rand_axis();
      r = $urandom_range(9);
      if (r < 3)
         t.buttons = prev_buttons;
      else if (r < 6)
         t.buttons = 8'($urandom);
      else
         t.buttons = 8'(9'd1 << $urandom_range(8));
      return t;
   endfunction

   task automatic test_random();
      req_type t;
      logic [7:0] prev_buttons;
      prev_buttons = 8'h00;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       write_config(DEADBAND_RST, MAX_VELOCITY_RST, 1'b0);
            1:       write_config(15'd0, VEL_CAP, 1'b1);
            2:       write_config(15'd32767, 15'd0, 1'b0);
            3:       write_config(15'($urandom_range(8000)), 15'($urandom), 1'b1);
            default: write_config(15'($urandom), 15'($urandom_range(25600)), 1'b0);
         endcase
         for (int i = 0; i < 80; i++) begin
            if (i % 30 == 0)
               idle_gaps = ($urandom_range(3) != 0);
            t = rand_tick(prev_buttons);
            prev_buttons = t.buttons;
            send_tick(t);
         end
         idle_gaps = 1'b1;
         wait_idle();
      end
   endtask

   // receiver holds off while back-to-back heavy ticks pile up behind it
   task automatic test_backpressure();
      idle_gaps = 1'b0;
      hold_len = 200;
      hold_seq++;
      for (int i = 0; i < 24; i++) begin
         if (i % 2 == 0)
            send_tick(make_tick(1'b1, 1'b1, 16'($urandom), 16'sd0, 16'sd0, 8'h0A));
         else
            send_tick(make_tick(1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 8'h20));
      end
      idle_gaps = 1'b1;
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random();
      $display("Ran %0d ticks (%0d ignored) under %0d register settings, %0d commands checked",
               ticks_accepted, ignored_ticks, settings_used, cmds_checked);
      $display("Input side was held off for %0d cycles in total", input_stall_cycles);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d commands still expected", pending_cmds.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: dual_arm_jog_command_mapper_core.f
rtl/core/dajcm_pkg.sv
rtl/core/dajcm_front.sv
rtl/core/dajcm_queue.sv
rtl/core/dajcm_back.sv
rtl/core/dual_arm_jog_command_mapper_core.sv
verif/tb_dual_arm_jog_command_mapper_core.sv
